### hdl/gldn_pkg.sv
package gldn_pkg;

    localparam int COUNT_WIDTH     = 16;
    localparam int MAX_GAP_POINTS  = 62;
    localparam int GAP_WIDTH       = $clog2(MAX_GAP_POINTS + 2);
    localparam int SAMPLE_WIDTH    = 32;
    localparam int DIFF_WIDTH      = SAMPLE_WIDTH + 1;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int FDIV_CNT_WIDTH  = $clog2(COUNT_WIDTH);
    localparam int BDIV_CNT_WIDTH  = $clog2(DIFF_WIDTH);
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_WIDTH      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_SAMPLE_COUNT = 1'b0,
        CFG_TARGET_COUNT = 1'b1
    } cfg_index_t;

    typedef enum logic {
        F_IDLE,
        F_DIV
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_EMIT
    } back_state_t;

    // one queued request: a pass-through sample or one gap to fill
    typedef struct packed {
        logic                           is_gap;
        logic                           last;
        logic                           clamped;
        logic [GAP_WIDTH-1:0]           k;
        logic signed [SAMPLE_WIDTH-1:0] start;
        logic signed [SAMPLE_WIDTH-1:0] stop;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### hdl/grid_linear_densifier_core.sv
// Linear-interpolation upsampler for a grid of sample_count Q16.16 samples,
// spreading target_count - sample_count new points over the gaps. A sample is
// classified on arrival and queued (two entries); a pass-through sample goes
// from the queue to the job register and then to the output register. The
// first sample of a densified grid runs a serial divide for the gap counts and
// gives no result. Each gap runs a serial divide for its step (skipped when it
// gets no points), then emits one point per cycle unless the output stalls:
// start, k inserted points and, on the last gap, the end sample (k <= 62).
module grid_linear_densifier_core
    import gldn_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] point,
    output logic                           run_last,
    output logic                           grid_last,
    output logic                           count_clamped
);

    logic [CFG_DATA_WIDTH-1:0] sample_count_reg;
    logic [CFG_DATA_WIDTH-1:0] sample_count_next;
    logic [CFG_DATA_WIDTH-1:0] target_count_reg;
    logic [CFG_DATA_WIDTH-1:0] target_count_next;

    logic          push;
    job_t          push_job;
    logic          pop;
    job_t          pop_job;
    queue_status_t q_status;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        sample_count_next = sample_count_reg;
        target_count_next = target_count_reg;
        if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SAMPLE_COUNT: sample_count_next = cfg_data;
                CFG_TARGET_COUNT: target_count_next = cfg_data;
                default:          sample_count_next = sample_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= '0;
            target_count_reg <= '0;
        end
        else
        begin
            sample_count_reg <= sample_count_next;
            target_count_reg <= target_count_next;
        end
    end

    gldn_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .sample_count (COUNT_WIDTH'(sample_count_reg)),
        .target_count (COUNT_WIDTH'(target_count_reg)),
        .q_status     (q_status),
        .push         (push),
        .push_job     (push_job)
    );

    gldn_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    gldn_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .pop           (pop),
        .pop_job       (pop_job),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .point         (point),
        .run_last      (run_last),
        .grid_last     (grid_last),
        .count_clamped (count_clamped)
    );

endmodule

### hdl/gldn_queue.sv
module gldn_queue
    import gldn_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  job_t          push_job,
    input  logic          pop,
    output job_t          pop_job,
    output queue_status_t status
);

    job_t                  mem_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg;
    logic [QPTR_WIDTH-1:0] wr_ptr_next;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg;
    logic [QPTR_WIDTH-1:0] rd_ptr_next;
    logic [QCNT_WIDTH-1:0] count_reg;
    logic [QCNT_WIDTH-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign pop_job      = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_WIDTH'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

### hdl/gldn_front.sv
module gldn_front
    import gldn_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic [COUNT_WIDTH-1:0]         sample_count,
    input  logic [COUNT_WIDTH-1:0]         target_count,
    input  queue_status_t                  q_status,
    output logic                           push,
    output job_t                           push_job
);

    front_state_t                   state_reg;
    front_state_t                   state_next;
    logic signed [SAMPLE_WIDTH-1:0] prev_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_next;
    logic [COUNT_WIDTH-1:0]         idx_reg;
    logic [COUNT_WIDTH-1:0]         idx_next;
    logic [COUNT_WIDTH-1:0]         base_reg;
    logic [COUNT_WIDTH-1:0]         base_next;
    logic [COUNT_WIDTH-1:0]         extra_reg;
    logic [COUNT_WIDTH-1:0]         extra_next;
    logic [COUNT_WIDTH-1:0]         div_quo_reg;
    logic [COUNT_WIDTH-1:0]         div_quo_next;
    logic [COUNT_WIDTH-1:0]         div_rem_reg;
    logic [COUNT_WIDTH-1:0]         div_rem_next;
    logic [COUNT_WIDTH-1:0]         div_den_reg;
    logic [COUNT_WIDTH-1:0]         div_den_next;
    logic [FDIV_CNT_WIDTH-1:0]      div_cnt_reg;
    logic [FDIV_CNT_WIDTH-1:0]      div_cnt_next;

    logic                   accept;
    logic [COUNT_WIDTH:0]   idx_inc;
    logic                   last;
    logic                   densify;
    logic                   idx_zero;
    logic [COUNT_WIDTH-1:0] gap;
    logic [COUNT_WIDTH:0]   k_raw;
    logic                   clamp;
    logic [GAP_WIDTH-1:0]   k;
    logic [COUNT_WIDTH:0]   rem_sh;
    logic                   rem_ge;
    logic [COUNT_WIDTH-1:0] rem_new;
    logic [COUNT_WIDTH-1:0] quo_new;

    assign in_ready = (state_reg == F_IDLE) && !q_status.full;
    assign accept   = in_valid && in_ready;
    assign idx_inc  = {1'b0, idx_reg} + 1'b1;
    assign last     = idx_inc >= {1'b0, sample_count};
    assign densify  = (sample_count >= COUNT_WIDTH'(2)) && (target_count > sample_count);
    assign idx_zero = (idx_reg == '0);
    assign gap      = idx_reg - 1'b1;
    assign k_raw    = {1'b0, base_reg} + ((gap < extra_reg) ? 1'b1 : 1'b0);
    assign clamp    = k_raw > (COUNT_WIDTH + 1)'(MAX_GAP_POINTS);
    assign k        = clamp ? GAP_WIDTH'(MAX_GAP_POINTS) : GAP_WIDTH'(k_raw);

    // restoring divider for the per-gap insert count
    assign rem_sh  = {div_rem_reg, div_quo_reg[COUNT_WIDTH-1]};
    assign rem_ge  = rem_sh >= {1'b0, div_den_reg};
    assign rem_new = rem_ge ? COUNT_WIDTH'(rem_sh - {1'b0, div_den_reg})
                            : COUNT_WIDTH'(rem_sh);
    assign quo_new = {div_quo_reg[COUNT_WIDTH-2:0], rem_ge};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept && idx_zero && densify)
                begin
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        prev_next      = prev_reg;
        idx_next       = idx_reg;
        base_next      = base_reg;
        extra_next     = extra_reg;
        div_quo_next   = div_quo_reg;
        div_rem_next   = div_rem_reg;
        div_den_next   = div_den_reg;
        div_cnt_next   = div_cnt_reg;
        push           = 1'b0;
        push_job.is_gap  = densify;
        push_job.last    = last;
        push_job.clamped = clamp;
        push_job.k       = k;
        push_job.start   = prev_reg;
        push_job.stop    = sample;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    prev_next = sample;
                    idx_next  = last ? '0 : COUNT_WIDTH'(idx_inc);
                    if (idx_zero && densify)
                    begin
                        div_quo_next = target_count - sample_count;
                        div_den_next = sample_count - 1'b1;
                        div_rem_next = '0;
                        div_cnt_next = FDIV_CNT_WIDTH'(COUNT_WIDTH - 1);
                    end
                    else
                    begin
                        push = 1'b1;
                        if (idx_zero)
                        begin
                            base_next  = '0;
                            extra_next = '0;
                        end
                    end
                end
            end
            F_DIV:
            begin
                div_quo_next = quo_new;
                div_rem_next = rem_new;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    base_next  = quo_new;
                    extra_next = rem_new;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            prev_reg  <= '0;
            idx_reg   <= '0;
            base_reg  <= '0;
            extra_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            prev_reg  <= prev_next;
            idx_reg   <= idx_next;
            base_reg  <= base_next;
            extra_reg <= extra_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_quo_reg <= div_quo_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        div_cnt_reg <= div_cnt_next;
    end

endmodule

### hdl/gldn_back.sv
module gldn_back
    import gldn_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  queue_status_t                  q_status,
    output logic                           pop,
    input  job_t                           pop_job,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] point,
    output logic                           run_last,
    output logic                           grid_last,
    output logic                           count_clamped
);

    back_state_t                    state_reg;
    back_state_t                    state_next;
    job_t                           job_reg;
    job_t                           job_next;
    logic [BDIV_CNT_WIDTH-1:0]      cnt_reg;
    logic [BDIV_CNT_WIDTH-1:0]      cnt_next;
    logic [GAP_WIDTH-1:0]           rem_reg;
    logic [GAP_WIDTH-1:0]           rem_next;
    logic [DIFF_WIDTH-1:0]          quo_reg;
    logic [DIFF_WIDTH-1:0]          quo_next;
    logic                           neg_reg;
    logic                           neg_next;
    logic [SAMPLE_WIDTH-1:0]        step_reg;
    logic [SAMPLE_WIDTH-1:0]        step_next;
    logic [SAMPLE_WIDTH-1:0]        acc_reg;
    logic [SAMPLE_WIDTH-1:0]        acc_next;
    logic [GAP_WIDTH-1:0]           pos_reg;
    logic [GAP_WIDTH-1:0]           pos_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] point_reg;
    logic signed [SAMPLE_WIDTH-1:0] point_next;
    logic                           run_last_reg;
    logic                           run_last_next;
    logic                           grid_last_reg;
    logic                           grid_last_next;
    logic                           clamped_reg;
    logic                           clamped_next;

    logic                  slot_free;
    logic                  emit;
    logic                  final_pt;
    logic [GAP_WIDTH-1:0]  final_pos;
    logic [GAP_WIDTH-1:0]  den;
    logic [GAP_WIDTH:0]    rem_sh;
    logic                  rem_ge;
    logic [GAP_WIDTH-1:0]  rem_new;
    logic [DIFF_WIDTH-1:0] quo_new;
    logic [DIFF_WIDTH-1:0] diff;
    logic [SAMPLE_WIDTH-1:0] interp;

    assign slot_free = !out_valid_reg || out_ready;
    assign emit      = (state_reg == B_EMIT) && slot_free;
    assign final_pos = job_reg.k + (job_reg.last ? 1'b1 : 1'b0);
    assign final_pt  = !job_reg.is_gap || (pos_reg == final_pos);
    assign pop       = (state_reg == B_IDLE) && !q_status.empty;
    assign diff      = {pop_job.stop[SAMPLE_WIDTH-1], pop_job.stop}
                     - {pop_job.start[SAMPLE_WIDTH-1], pop_job.start};
    assign interp    = acc_reg + step_reg;

    // one quotient bit per cycle, magnitude only
    assign den     = job_reg.k + 1'b1;
    assign rem_sh  = {rem_reg, quo_reg[DIFF_WIDTH-1]};
    assign rem_ge  = rem_sh >= {1'b0, den};
    assign rem_new = rem_ge ? GAP_WIDTH'(rem_sh - {1'b0, den}) : GAP_WIDTH'(rem_sh);
    assign quo_new = {quo_reg[DIFF_WIDTH-2:0], rem_ge};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = (pop_job.is_gap && (pop_job.k != '0)) ? B_DIV : B_EMIT;
                end
            end
            B_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (slot_free && final_pt)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        job_next       = job_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        point_next     = point_reg;
        run_last_next  = run_last_reg;
        grid_last_next = grid_last_reg;
        clamped_next   = clamped_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    job_next = pop_job;
                    neg_next = diff[DIFF_WIDTH-1];
                    quo_next = diff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-diff) : diff;
                    rem_next = '0;
                    cnt_next = BDIV_CNT_WIDTH'(DIFF_WIDTH - 1);
                    acc_next = pop_job.start;
                    pos_next = '0;
                end
            end
            B_DIV:
            begin
                quo_next = quo_new;
                rem_next = rem_new;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    step_next = neg_reg ? SAMPLE_WIDTH'(-quo_new) : quo_new[SAMPLE_WIDTH-1:0];
                end
            end
            B_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    run_last_next  = final_pt;
                    pos_next       = pos_reg + 1'b1;
                    if (!job_reg.is_gap)
                    begin
                        point_next     = job_reg.stop;
                        grid_last_next = job_reg.last;
                        clamped_next   = 1'b0;
                    end
                    else if (pos_reg == '0)
                    begin
                        point_next     = job_reg.start;
                        grid_last_next = 1'b0;
                        clamped_next   = job_reg.clamped;
                    end
                    else if (pos_reg > job_reg.k)
                    begin
                        point_next     = job_reg.stop;
                        grid_last_next = 1'b1;
                        clamped_next   = 1'b0;
                    end
                    else
                    begin
                        point_next     = interp;
                        acc_next       = interp;
                        grid_last_next = 1'b0;
                        clamped_next   = job_reg.clamped;
                    end
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        cnt_reg       <= cnt_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        neg_reg       <= neg_next;
        step_reg      <= step_next;
        acc_reg       <= acc_next;
        pos_reg       <= pos_next;
        point_reg     <= point_next;
        run_last_reg  <= run_last_next;
        grid_last_reg <= grid_last_next;
        clamped_reg   <= clamped_next;
    end

    assign out_valid     = out_valid_reg;
    assign point         = point_reg;
    assign run_last      = run_last_reg;
    assign grid_last     = grid_last_reg;
    assign count_clamped = clamped_reg;

endmodule

### hdl/gldn_checker.sv
module gldn_checker
    import gldn_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] point,
    input  logic                           run_last,
    input  logic                           grid_last,
    input  logic                           count_clamped
);

    a_point_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(point))
        else $error("point changed while stalled");

    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(run_last) && $stable(grid_last) && $stable(count_clamped))
        else $error("flags changed while stalled");

    a_grid_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && grid_last |-> run_last)
        else $error("grid end not on last result of request");

    a_clamp_not_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count_clamped |-> !grid_last)
        else $error("clamp flag on final sample");

endmodule

bind grid_linear_densifier_core gldn_checker u_gldn_checker (.*);
